FILE: hw/rtl/stl_pkg.sv
// Package for the sorted timer list: sizes, codes, shared types and helpers.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

   // Store size and derived widths
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RES_MAX = 16;
   localparam int FIRE_W  = $clog2(RES_MAX + 1);

   // Field widths
   localparam int ID_W    = 16;
   localparam int DLY_W   = 24;
   localparam int TIME_W  = 48;
   localparam int STEP_W  = 10;

   // Request codes
   localparam logic [1:0] REQ_SET    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PARAM   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_EXPIRED = 2'd3;

   // One stored timer
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] dl;
      logic [DLY_W-1:0]  per;
   } entry_type;

   // Slot memory access for one cycle
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_req_type;

   // One request item
   typedef struct packed {
      logic [1:0]       op;
      logic [ID_W-1:0]  tmr_id;
      logic [DLY_W-1:0] delay_ms;
      logic [DLY_W-1:0] period_ms;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   fired_id;
      logic              next_valid;
      logic [TIME_W-1:0] next_deadline;
      logic              last;
   } rsp_item_type;

   // Saturating 48-bit add
   function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_timer_list_top.sv
// Sorted timer list top level: channels, tick step register, result register.
// Keeps up to 16 one-shot or periodic timers sorted by deadline in a slot memory
// (one registered read and one write per cycle), equal deadlines in arrival order.
// Pending timers always fill slots 0..n-1, so a fill count stands for the valid
// bits and no clearing pass runs after reset. A valid set, a cancel and each
// expired timer walk the slot memory one entry at a time (read, then compare
// and write back); every operation then reads the head to report the next
// deadline. A tick reports at most 16 expired timers. One item is worked on
// at a time; req_ready is high only while the block is idle. Results pass
// through a one-entry output register. csr_tick_step is always accepted and
// must be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_list_top
   import stl_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_type,
   input  wire  [ID_W-1:0]    req_tmr_id,
   input  wire  [DLY_W-1:0]   req_delay_ms,
   input  wire  [DLY_W-1:0]   req_period_ms,
   // result channel
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_fired_id,
   output logic               rsp_next_valid,
   output logic [TIME_W-1:0]  rsp_next_deadline,
   output logic               rsp_last,
   // tick step register
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [STEP_W-1:0]  csr_tick_step
);

   req_item_type      req_item;
   rsp_item_type      res_item;
   logic              res_valid;
   logic              res_ready;
   ram_req_type       mem_req;
   entry_type         rd_data;

   logic [STEP_W-1:0] tick_step_ff;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff;

   assign req_item.op        = req_type;
   assign req_item.tmr_id    = req_tmr_id;
   assign req_item.delay_ms  = req_delay_ms;
   assign req_item.period_ms = req_period_ms;

   // Tick step register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= STEP_W'(1);
      end else if (csr_valid) begin
         tick_step_ff <= csr_tick_step;
      end
   end

   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .tick_step (tick_step_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   stl_slot_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Output register: loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res_item;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_fired_id      = rsp_ff.fired_id;
   assign rsp_next_valid    = rsp_ff.next_valid;
   assign rsp_next_deadline = rsp_ff.next_deadline;
   assign rsp_last          = rsp_ff.last;

endmodule

`default_nettype wire

FILE: hw/rtl/stl_slot_ram.sv
// Timer slot memory: one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module stl_slot_ram
   import stl_pkg::*;
(
   input  wire         clock,
   input  ram_req_type mem_req,
   output entry_type   rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/stl_ctrl.sv
// Timer list sequencer: sorted insert, cancel compaction, expiry and result build.
`timescale 1ns / 1ps
`default_nettype none

module stl_ctrl
   import stl_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  req_item_type       req_item,
   input  wire  [STEP_W-1:0]  tick_step,
   output logic               res_valid,
   input  wire                res_ready,
   output rsp_item_type       res_item,
   output ram_req_type        mem_req,
   input  entry_type          rd_data
);

   // Sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_CMP = 4'd2;
   localparam logic [3:0] S_CAN_RD  = 4'd3;
   localparam logic [3:0] S_CAN_CMP = 4'd4;
   localparam logic [3:0] S_HEAD    = 4'd5;
   localparam logic [3:0] S_HEAD_W  = 4'd6;
   localparam logic [3:0] S_FIRE    = 4'd7;
   localparam logic [3:0] S_FIR_RD  = 4'd8;
   localparam logic [3:0] S_FIR_CMP = 4'd9;
   localparam logic [3:0] S_EMIT    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [1:0]        op_ff, op_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  wptr_ff, wptr_in;
   logic [FIRE_W-1:0] fires_ff, fires_in;
   logic              one_shot_ff, one_shot_in;
   logic              last_ff, last_in;
   entry_type         new_ff, new_in;
   entry_type         head_ff, head_in;

   logic [CNT_W-1:0]  scan_dec;
   logic [CNT_W-1:0]  scan_inc;
   logic              fire_next;

   assign scan_dec = scan_ff - CNT_W'(1);
   assign scan_inc = scan_ff + CNT_W'(1);

   // Head of list is due and this tick still has result room
   assign fire_next = (op_ff == REQ_TICK) && (count_ff != '0) &&
                      (rd_data.dl <= now_ff) && (fires_ff < FIRE_W'(RES_MAX));

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);

   // Result fields
   always_comb begin
      res_item.status        = status_ff;
      res_item.fired_id      = (status_ff == ST_EXPIRED) ? new_ff.id : '0;
      res_item.next_valid    = (count_ff != '0);
      res_item.next_deadline = (count_ff != '0) ? head_ff.dl : '0;
      res_item.last          = last_ff;
   end

   // Next-state and memory access
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      scan_in     = scan_ff;
      wptr_in     = wptr_ff;
      fires_in    = fires_ff;
      one_shot_in = one_shot_ff;
      last_in     = last_ff;
      new_in      = new_ff;
      head_in     = head_ff;
      mem_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_item.op;
               new_in.id  = req_item.tmr_id;
               new_in.dl  = sat_add48(now_ff, TIME_W'(req_item.delay_ms));
               new_in.per = req_item.period_ms;
               status_in  = ST_OK;
               fires_in   = '0;
               last_in    = 1'b1;
               unique case (req_item.op)
                  REQ_SET: begin
                     if (req_item.delay_ms == '0) begin
                        status_in = ST_PARAM;
                        state_in  = S_HEAD;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                        state_in  = S_HEAD;
                     end else begin
                        scan_in  = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  REQ_CANCEL: begin
                     scan_in  = '0;
                     wptr_in  = '0;
                     state_in = S_CAN_RD;
                  end
                  REQ_TICK: begin
                     now_in   = sat_add48(now_ff, TIME_W'(tick_step));
                     state_in = S_HEAD;
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                     state_in = S_HEAD;
                  end
               endcase
            end
         end

         // Walk down from the tail, moving later deadlines up one slot
         S_INS_RD: begin
            if (scan_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = '0;
               mem_req.wr_data = new_ff;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_HEAD;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_dec[IDX_W-1:0];
               state_in        = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_ff[IDX_W-1:0];
            if (new_ff.dl < rd_data.dl) begin
               mem_req.wr_data = rd_data;
               scan_in         = scan_dec;
               state_in        = S_INS_RD;
            end else begin
               mem_req.wr_data = new_ff;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_HEAD;
            end
         end

         // Compaction: keep entries whose id differs
         S_CAN_RD: begin
            if (scan_ff == count_ff) begin
               count_in = wptr_ff;
               state_in = S_HEAD;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_ff[IDX_W-1:0];
               state_in        = S_CAN_CMP;
            end
         end

         S_CAN_CMP: begin
            if (rd_data.id != new_ff.id) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wptr_ff[IDX_W-1:0];
               mem_req.wr_data = rd_data;
               wptr_in         = wptr_ff + CNT_W'(1);
            end
            scan_in  = scan_inc;
            state_in = S_CAN_RD;
         end

         S_HEAD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_in        = S_HEAD_W;
         end

         // Head captured; decide whether a tick fires first or reports
         S_HEAD_W: begin
            head_in = rd_data;
            if (op_ff == REQ_TICK) begin
               last_in = !fire_next;
               if (fire_next && (fires_ff == '0)) begin
                  state_in = S_FIRE;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (res_ready) begin
               state_in = last_ff ? S_IDLE : S_FIRE;
            end
         end

         // Pop the head; a periodic timer goes back in at its next deadline
         S_FIRE: begin
            new_in.id   = head_ff.id;
            new_in.dl   = sat_add48(head_ff.dl, TIME_W'(head_ff.per));
            new_in.per  = head_ff.per;
            one_shot_in = (head_ff.per == '0);
            scan_in     = CNT_W'(1);
            fires_in    = fires_ff + FIRE_W'(1);
            status_in   = ST_EXPIRED;
            state_in    = S_FIR_RD;
         end

         S_FIR_RD: begin
            if (scan_ff == count_ff) begin
               if (one_shot_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = scan_dec[IDX_W-1:0];
                  mem_req.wr_data = new_ff;
               end
               state_in = S_HEAD;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_ff[IDX_W-1:0];
               state_in        = S_FIR_CMP;
            end
         end

         S_FIR_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_dec[IDX_W-1:0];
            if (one_shot_ff || (rd_data.dl <= new_ff.dl)) begin
               mem_req.wr_data = rd_data;
               scan_in         = scan_inc;
               state_in        = S_FIR_RD;
            end else begin
               mem_req.wr_data = new_ff;
               state_in        = S_HEAD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         now_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         now_ff   <= now_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      status_ff   <= status_in;
      scan_ff     <= scan_in;
      wptr_ff     <= wptr_in;
      fires_ff    <= fires_in;
      one_shot_ff <= one_shot_in;
      last_ff     <= last_in;
      new_ff      <= new_in;
      head_ff     <= head_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/stl_checker.sv
// Port-level checks for the sorted timer list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stl_checker
   import stl_pkg::*;
(
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire [1:0]          rsp_status,
   input wire [ID_W-1:0]     rsp_fired_id,
   input wire                rsp_next_valid,
   input wire [TIME_W-1:0]   rsp_next_deadline,
   input wire                rsp_last
);

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_fired_id, rsp_next_valid, rsp_next_deadline, rsp_last}))
      else $error("result changed while stalled");

   // Only expiry reports carry an id; any other status ends its item
   a_non_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_EXPIRED) |-> (rsp_fired_id == '0) && rsp_last)
      else $error("non-expiry result with id or without last");

   // Empty list reports a zero deadline
   a_empty_deadline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_next_valid |-> (rsp_next_deadline == '0))
      else $error("deadline reported for empty list");

   // One request in flight: accepting drops ready
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind sorted_timer_list_top stl_checker u_stl_checker (.*);

`default_nettype wire
